// ===== rtl/zsce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsce_pkg
// Shared types and constants of the zoomed sprite chunk expander.
// ----------------------------------------------------------------------------
package zsce_pkg;

    // Sprite map store geometry
    localparam int MAP_AW    = 17;
    localparam int MAP_DEPTH = 1 << MAP_AW;
    localparam int CODE_W    = 16;

    // Map code that marks a chunk as not drawn
    localparam logic [CODE_W-1:0] INVALID_CODE = 16'hffff;

    // Position folding
    localparam logic signed [12:0] POS_FOLD_LIMIT = 13'sh340;
    localparam logic signed [12:0] POS_FOLD_SPAN  = 13'sh400;

    // Palette bank base, priority is ORed into the top two bits of the palette field
    localparam logic [8:0] PAL_BANK_BASE = 9'h100;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_OFFSET     = 3'd0,
        CFG_Y_OFFSET     = 3'd1,
        CFG_PRIMASK_BNK0 = 3'd2,
        CFG_PRIMASK_BNK1 = 3'd3,
        CFG_PRIMASK_BNK2 = 3'd4,
        CFG_PRIMASK_BNK3 = 3'd5
    } t_cfg_index;

    // Request kinds
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SPRITE = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

endpackage

// ===== rtl/zsce_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsce_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module zsce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/zoomed_sprite_chunk_expander_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zoomed_sprite_chunk_expander_core
// Keeps the sprite map and expands a sprite request into its 2x2 or 4x4 chunk
// descriptors, one chunk per cycle, in row-major screen order.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                     payload
//  request   in         start & !busy                 req_type, map_*, entry_word*
//  config    in         i_cfg_valid & o_cfg_ready     i_cfg_index, i_cfg_data
//  result    out        o_res_strobe (one cycle)      chunk descriptor fields
//
//  A load request writes the map in its accept cycle; busy stays low.
//  A sprite of tile zero gives no result; busy stays low.
//  A sprite keeps busy high while its N = 4 or 16 chunks are looked up and until its
//  last result is out: the map RAM has one read port, so one chunk is looked up per cycle.
//  Reset clears the sequencer and loads the register defaults; the map is not
//  cleared and must be written before it is read. Results cannot be stalled.
// ----------------------------------------------------------------------------
module zoomed_sprite_chunk_expander_core
    import zsce_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        start,
    output logic                        busy,
    input  logic                        i_req_type,
    input  logic [16:0]                 i_map_address,
    input  logic [15:0]                 i_map_word,
    input  logic [31:0]                 i_entry_word0,
    input  logic [31:0]                 i_entry_word2,
    input  logic [31:0]                 i_entry_word3,

    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [15:0]                 i_cfg_data,

    output logic                        o_res_strobe,
    output logic [15:0]                 o_tile_code,
    output logic [7:0]                  o_palette,
    output logic                        o_mirror_x,
    output logic                        o_mirror_y,
    output logic signed [11:0]          o_pos_x,
    output logic signed [11:0]          o_pos_y,
    output logic [6:0]                  o_chunk_width,
    output logic [6:0]                  o_chunk_height,
    output logic [15:0]                 o_priority_mask,
    output logic                        o_chunk_valid,
    output logic                        o_last_chunk
);

    // Configuration registers
    logic signed [10:0] r_x_offset;
    logic signed [10:0] r_y_offset;
    logic [15:0]        r_primask [4];

    // Sprite registers, held for the whole expansion
    logic [14:0]        r_tile;
    logic               r_flipx;
    logic               r_flipy;
    logic               r_dbl;
    logic [7:0]         r_zoomx;
    logic [7:0]         r_zoomy;
    logic [11:0]        r_base_x;
    logic [11:0]        r_base_y;
    logic [7:0]         r_pal;
    logic [15:0]        r_pmask;

    // Sequencer
    t_state             r_state;
    t_state             n_state;
    logic [1:0]         r_k;
    logic [1:0]         r_j;
    logic [8:0]         r_accx;
    logic [8:0]         r_accy;

    // Result stage, aligned with the RAM read data
    logic               r_out_vld;
    logic [11:0]        r_out_pos_x;
    logic [11:0]        r_out_pos_y;
    logic [6:0]         r_out_w;
    logic [6:0]         r_out_h;
    logic               r_out_last;

    logic               w_accept;
    logic               w_load;
    logic               w_sprite;
    logic               w_step;
    logic               w_row_end;
    logic               w_last;

    // Request decode
    logic [14:0]        d_tile;
    logic [9:0]         d_x10;
    logic [9:0]         d_yneg;
    logic signed [12:0] d_x_raw;
    logic signed [12:0] d_x_fold;
    logic signed [12:0] d_x_pos;
    logic signed [12:0] d_y_sum;
    logic signed [12:0] d_y_fold;
    logic [8:0]         d_pal_or;
    logic [1:0]         d_prio;

    // Chunk arithmetic
    logic [1:0]         w_dim_last;
    logic [1:0]         w_px;
    logic [1:0]         w_py;
    logic [3:0]         w_off;
    logic [MAP_AW-1:0]  w_raddr;
    logic [9:0]         w_endx;
    logic [9:0]         w_endy;
    logic [7:0]         w_ox0;
    logic [7:0]         w_ox1;
    logic [7:0]         w_oy0;
    logic [7:0]         w_oy1;
    logic [7:0]         w_wid;
    logic [7:0]         w_hgt;
    logic [15:0]        w_rdata;

    assign busy        = (r_state != ST_IDLE) || r_out_vld;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;
    assign w_load      = w_accept && (i_req_type == REQ_LOAD);
    assign d_tile      = i_entry_word0[14:0];
    assign w_sprite    = w_accept && (i_req_type == REQ_SPRITE) && (d_tile != 15'd0);

    // ------------------------------------------------------------------
    // Position and palette decode of a sprite request
    // ------------------------------------------------------------------
    always_comb begin
        d_x10    = i_entry_word2[9:0];
        d_x_raw  = signed'({3'b000, d_x10});
        d_x_fold = (d_x_raw > POS_FOLD_LIMIT) ? d_x_raw - POS_FOLD_SPAN : d_x_raw;
        d_x_pos  = d_x_fold - {{2{r_x_offset[10]}}, r_x_offset};
        d_yneg   = 10'd0 - i_entry_word3[9:0];
        d_y_sum  = signed'({3'b000, d_yneg}) + {{2{r_y_offset[10]}}, r_y_offset};
        d_y_fold = (d_y_sum > POS_FOLD_LIMIT) ? d_y_sum - POS_FOLD_SPAN : d_y_sum;
        d_prio   = i_entry_word2[19:18];
        d_pal_or = {1'b0, i_entry_word2[17:10]} | (PAL_BANK_BASE + {1'b0, d_prio, 6'b0});
    end

    // ------------------------------------------------------------------
    // Chunk address and zoomed extent of the current chunk
    // ------------------------------------------------------------------
    always_comb begin
        w_dim_last = r_dbl ? 2'd3 : 2'd1;
        w_px       = r_flipx ? (r_k ^ w_dim_last) : r_k;
        w_py       = r_flipy ? (r_j ^ w_dim_last) : r_j;
        w_off      = r_dbl ? {w_py, w_px} : {2'b00, w_py[0], w_px[0]};
        w_raddr    = MAP_AW'({r_tile, 2'b00} + {13'd0, w_off});
        w_endx     = {1'b0, r_accx} + {2'b00, r_zoomx};
        w_endy     = {1'b0, r_accy} + {2'b00, r_zoomy};
        w_ox0      = r_dbl ? 8'(r_accx >> 2) : 8'(r_accx >> 1);
        w_ox1      = r_dbl ? 8'(w_endx >> 2) : 8'(w_endx >> 1);
        w_oy0      = r_dbl ? 8'(r_accy >> 2) : 8'(r_accy >> 1);
        w_oy1      = r_dbl ? 8'(w_endy >> 2) : 8'(w_endy >> 1);
        w_wid      = w_ox1 - w_ox0;
        w_hgt      = w_oy1 - w_oy0;
        w_row_end  = (r_k == w_dim_last);
        w_last     = w_row_end && (r_j == w_dim_last);
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_step  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_sprite) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                w_step = 1'b1;
                if (w_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sprite capture and chunk counters
    always_ff @(posedge i_clk) begin
        if (w_sprite) begin
            r_tile   <= d_tile;
            r_flipx  <= i_entry_word0[23];
            r_flipy  <= i_entry_word3[17];
            r_dbl    <= i_entry_word3[18];
            r_zoomx  <= {1'b0, i_entry_word0[22:16]} + 8'd1;
            r_zoomy  <= {1'b0, i_entry_word3[16:10]} + 8'd1;
            r_base_x <= d_x_pos[11:0];
            r_base_y <= d_y_fold[11:0];
            r_pal    <= d_pal_or[8:1];
            r_pmask  <= r_primask[d_prio];
            r_k      <= 2'd0;
            r_j      <= 2'd0;
            r_accx   <= 9'd0;
            r_accy   <= 9'd0;
        end else if (w_step) begin
            // advance one column, wrap to the next row at the row end
            if (w_row_end) begin
                r_k    <= 2'd0;
                r_accx <= 9'd0;
                r_j    <= r_j + 2'd1;
                r_accy <= w_endy[8:0];
            end else begin
                r_k    <= r_k + 2'd1;
                r_accx <= w_endx[8:0];
            end
        end
    end

    // Result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_pos_x <= r_base_x + {4'd0, w_ox0};
            r_out_pos_y <= r_base_y + {4'd0, w_oy0};
            r_out_w     <= w_wid[6:0];
            r_out_h     <= w_hgt[6:0];
            r_out_last  <= w_last;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_offset   <= 11'sd44;
            r_y_offset   <= -11'sd574;
            r_primask[0] <= 16'hfffc;
            r_primask[1] <= 16'hfff0;
            r_primask[2] <= 16'hff00;
            r_primask[3] <= 16'h0000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_X_OFFSET:     r_x_offset   <= signed'(i_cfg_data[10:0]);
                CFG_Y_OFFSET:     r_y_offset   <= signed'(i_cfg_data[10:0]);
                CFG_PRIMASK_BNK0: r_primask[0] <= i_cfg_data;
                CFG_PRIMASK_BNK1: r_primask[1] <= i_cfg_data;
                CFG_PRIMASK_BNK2: r_primask[2] <= i_cfg_data;
                CFG_PRIMASK_BNK3: r_primask[3] <= i_cfg_data;
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sprite map
    // ------------------------------------------------------------------
    zsce_ram #(
        .WIDTH (CODE_W),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (i_map_address[MAP_AW-1:0]),
        .i_wdata (i_map_word),
        .i_re    (w_step),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_res_strobe    = r_out_vld;
    assign o_tile_code     = w_rdata;
    assign o_palette       = r_pal;
    assign o_mirror_x      = !r_flipx;
    assign o_mirror_y      = r_flipy;
    assign o_pos_x         = signed'(r_out_pos_x);
    assign o_pos_y         = signed'(r_out_pos_y);
    assign o_chunk_width   = r_out_w;
    assign o_chunk_height  = r_out_h;
    assign o_priority_mask = r_pmask;
    assign o_chunk_valid   = (w_rdata != INVALID_CODE);
    assign o_last_chunk    = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && o_last_chunk |=> !o_res_strobe)
        else $error("result after last chunk");

    a_burst_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && !o_last_chunk |=> o_res_strobe)
        else $error("gap inside a chunk burst");

    a_sprite_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sprite |=> (r_state == ST_RUN) && !o_res_strobe)
        else $error("sprite request did not start expansion");

    a_no_result_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !w_sprite |=> !busy)
        else $error("load or empty sprite left the block busy");

endmodule
